/* sv/grid_sync_mode_controller_unit_assert.svh */
// assertion macros for the grid sync mode controller
// expects clk and rst_n in the scope of each use
`ifndef GRID_SYNC_MODE_CONTROLLER_UNIT_ASSERT_SVH
`define GRID_SYNC_MODE_CONTROLLER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define GSMC_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define GSMC_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define GSMC_ASSERT_ALWAYS(lbl, expr, msg)
`define GSMC_ASSERT_IMPLY(lbl, ante, cons, msg)
`endif

`endif

/* sv/gsmc_pkg.sv */
// shared types and constants for the grid sync mode controller
// no dependencies
package gsmc_pkg;

    localparam int GSMC_TIMER_BITS = 48;
    localparam int FREQ_W          = 20;
    localparam int VOLT_W          = 16;
    localparam int VTOL_W          = 15;
    localparam int PERIOD_W        = 48;
    localparam int STEP_W          = 32;
    localparam int DATA_W          = 64;
    localparam int ADDR_W          = 6;
    localparam int IDX_LSB         = 3;
    localparam int IDX_W           = ADDR_W - IDX_LSB;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_ARM    = 2'd1,
        CMD_DISARM = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic {
        MODE_A = 1'b0,
        MODE_B = 1'b1
    } mode_t;

    localparam logic [IDX_W-1:0] REG_FREQ_UPPER = 3'd0;
    localparam logic [IDX_W-1:0] REG_FREQ_LOWER = 3'd1;
    localparam logic [IDX_W-1:0] REG_VOLT_TOL   = 3'd2;
    localparam logic [IDX_W-1:0] REG_CTRL_PER   = 3'd3;
    localparam logic [IDX_W-1:0] REG_MON_PER    = 3'd4;

    localparam logic signed [FREQ_W-1:0] FREQ_UPPER_RST = 20'sd660;
    localparam logic signed [FREQ_W-1:0] FREQ_LOWER_RST = 20'sd120;
    localparam logic [VTOL_W-1:0]        VOLT_TOL_RST   = 15'd100;
    localparam logic [PERIOD_W-1:0]      CTRL_PER_RST   = 48'd1000000000;
    localparam logic [PERIOD_W-1:0]      MON_PER_RST    = 48'd10000000000;

    typedef struct packed {
        logic signed [FREQ_W-1:0] freq_tol_upper;
        logic signed [FREQ_W-1:0] freq_tol_lower;
        logic [VTOL_W-1:0]        volt_tol;
        logic [PERIOD_W-1:0]      control_period_ns;
        logic [PERIOD_W-1:0]      monitor_period_ns;
    } cfg_t;

endpackage

/* sv/gsmc_regs.sv */
// configuration register file behind the apb-style port
// depends on gsmc_pkg
module gsmc_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gsmc_pkg::ADDR_W-1:0]  paddr,
    input  logic [gsmc_pkg::DATA_W-1:0]  pwdata,
    output logic [gsmc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output gsmc_pkg::cfg_t               cfg
);
    import gsmc_pkg::*;

    cfg_t             cfg_reg;
    logic [IDX_W-1:0] idx;
    logic             wr_en;

    assign idx    = paddr[ADDR_W-1:IDX_LSB];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.freq_tol_upper    <= FREQ_UPPER_RST;
            cfg_reg.freq_tol_lower    <= FREQ_LOWER_RST;
            cfg_reg.volt_tol          <= VOLT_TOL_RST;
            cfg_reg.control_period_ns <= CTRL_PER_RST;
            cfg_reg.monitor_period_ns <= MON_PER_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_FREQ_UPPER: cfg_reg.freq_tol_upper    <= pwdata[FREQ_W-1:0];
                REG_FREQ_LOWER: cfg_reg.freq_tol_lower    <= pwdata[FREQ_W-1:0];
                REG_VOLT_TOL:   cfg_reg.volt_tol          <= pwdata[VTOL_W-1:0];
                REG_CTRL_PER:   cfg_reg.control_period_ns <= pwdata[PERIOD_W-1:0];
                REG_MON_PER:    cfg_reg.monitor_period_ns <= pwdata[PERIOD_W-1:0];
                default:        ;
            endcase
        end
    end

    // signed fields read back sign extended
    always_comb
    begin
        unique case (idx)
            REG_FREQ_UPPER: prdata = DATA_W'(cfg_reg.freq_tol_upper);
            REG_FREQ_LOWER: prdata = DATA_W'(cfg_reg.freq_tol_lower);
            REG_VOLT_TOL:   prdata = DATA_W'(cfg_reg.volt_tol);
            REG_CTRL_PER:   prdata = DATA_W'(cfg_reg.control_period_ns);
            REG_MON_PER:    prdata = DATA_W'(cfg_reg.monitor_period_ns);
            default:        prdata = '0;
        endcase
    end

endmodule

/* sv/grid_sync_mode_controller_unit.sv */
// an accepted transaction passes the input register, one pass of compares and the
// saturating timer adds, then the result register
// throughput: one transaction per cycle while out_ready does not stall the output
// reset: rst_n asynchronous active low, clears controller state, timers and handshake,
// loads configuration defaults; no clearing pass
`include "grid_sync_mode_controller_unit_assert.svh"

module grid_sync_mode_controller_unit #(
    parameter int TIMER_BITS = gsmc_pkg::GSMC_TIMER_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gsmc_pkg::ADDR_W-1:0]         paddr,
    input  logic [gsmc_pkg::DATA_W-1:0]         pwdata,
    output logic [gsmc_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          cmd,
    input  logic [gsmc_pkg::STEP_W-1:0]         step_ns,
    input  logic                                switch_closed,
    input  logic                                check_armed,
    input  logic signed [gsmc_pkg::FREQ_W-1:0]  freq_diff,
    input  logic signed [gsmc_pkg::VOLT_W-1:0]  volt_diff_a,
    input  logic signed [gsmc_pkg::VOLT_W-1:0]  volt_diff_b,
    input  logic signed [gsmc_pkg::VOLT_W-1:0]  volt_diff_c,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                ctrl_armed,
    output logic                                mode_b,
    output logic                                arm_write,
    output logic                                arm_value,
    output logic                                gen_control_active
);
    import gsmc_pkg::*;

    localparam int CMP_W = (TIMER_BITS > PERIOD_W) ? TIMER_BITS : PERIOD_W;

    cfg_t cfg;

    gsmc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register
    logic                     in_vld_reg;
    cmd_t                     cmd_reg;
    logic [STEP_W-1:0]        step_reg;
    logic                     closed_reg;
    logic                     chk_reg;
    logic signed [FREQ_W-1:0] fd_reg;
    logic signed [VOLT_W-1:0] va_reg;
    logic signed [VOLT_W-1:0] vb_reg;
    logic signed [VOLT_W-1:0] vc_reg;

    // controller state
    logic                  armed_reg, armed_next;
    mode_t                 mode_reg, mode_next;
    logic [TIMER_BITS-1:0] timer_a_reg, timer_a_next;
    logic [TIMER_BITS-1:0] timer_b_reg, timer_b_next;

    // result register
    logic out_vld_reg;
    logic res_armed_reg, res_mode_reg, res_wr_reg, res_wv_reg, res_gen_reg;

    logic out_adv, fire, in_take;
    assign out_adv  = !out_vld_reg || out_ready;
    assign in_ready = !in_vld_reg || out_adv;
    assign fire     = in_vld_reg && out_adv;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg    <= cmd_t'(cmd);
            step_reg   <= step_ns;
            closed_reg <= switch_closed;
            chk_reg    <= check_armed;
            fd_reg     <= freq_diff;
            va_reg     <= volt_diff_a;
            vb_reg     <= volt_diff_b;
            vc_reg     <= volt_diff_c;
        end
    end

    // metrics, saturating timer adds and period compares
    logic signed [VOLT_W-1:0] vtol_s;
    logic                     ok, tick_on;
    logic [TIMER_BITS:0]      sum_a, sum_b;
    logic [TIMER_BITS-1:0]    ta_cand, tb_cand;
    logic                     a_done, b_done;

    always_comb
    begin
        vtol_s  = $signed({1'b0, cfg.volt_tol});
        ok      = (fd_reg >= cfg.freq_tol_lower) && (fd_reg <= cfg.freq_tol_upper) &&
                  (va_reg <= vtol_s) && (vb_reg <= vtol_s) && (vc_reg <= vtol_s);
        tick_on = (cmd_reg == CMD_TICK) && armed_reg && !closed_reg;
        sum_a   = {1'b0, timer_a_reg} + (TIMER_BITS+1)'(step_reg);
        sum_b   = {1'b0, timer_b_reg} + (TIMER_BITS+1)'(step_reg);
        if (!ok)
            ta_cand = '0;
        else if (sum_a[TIMER_BITS])
            ta_cand = '1;
        else
            ta_cand = sum_a[TIMER_BITS-1:0];
        tb_cand = sum_b[TIMER_BITS] ? '1 : sum_b[TIMER_BITS-1:0];
        a_done  = CMP_W'(ta_cand) >= CMP_W'(cfg.control_period_ns);
        b_done  = CMP_W'(tb_cand) >= CMP_W'(cfg.monitor_period_ns);
    end

    // next state
    always_comb
    begin
        armed_next   = armed_reg;
        mode_next    = mode_reg;
        timer_a_next = timer_a_reg;
        timer_b_next = timer_b_reg;
        unique case (cmd_reg)
            CMD_ARM:    armed_next = 1'b1;
            CMD_DISARM: armed_next = 1'b0;
            CMD_TICK:
            begin
                if (armed_reg && closed_reg)
                begin
                    armed_next = 1'b0;
                end
                else if (tick_on)
                begin
                    unique case (mode_reg)
                        MODE_A:
                        begin
                            if (a_done)
                            begin
                                timer_a_next = '0;
                                timer_b_next = '0;
                                mode_next    = MODE_B;
                            end
                            else
                            begin
                                timer_a_next = ta_cand;
                            end
                        end
                        MODE_B:
                        begin
                            if (ok && !b_done)
                            begin
                                timer_b_next = tb_cand;
                            end
                            else
                            begin
                                timer_a_next = '0;
                                timer_b_next = '0;
                                mode_next    = MODE_A;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // per-transaction outputs
    logic wr, wv, gen;

    always_comb
    begin
        wr  = 1'b0;
        wv  = 1'b0;
        gen = 1'b0;
        if (tick_on)
        begin
            unique case (mode_reg)
                MODE_A:
                begin
                    if (a_done)
                    begin
                        wr = 1'b1;
                        wv = 1'b1;
                    end
                    else
                    begin
                        wr  = chk_reg;
                        gen = 1'b1;
                    end
                end
                MODE_B:
                begin
                    // expiry in the same tick overrides the arm write
                    if (ok && !b_done)
                    begin
                        wr = !chk_reg;
                        wv = 1'b1;
                    end
                    else
                    begin
                        wr = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg   <= 1'b0;
            mode_reg    <= MODE_A;
            timer_a_reg <= '0;
            timer_b_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                armed_reg   <= armed_next;
                mode_reg    <= mode_next;
                timer_a_reg <= timer_a_next;
                timer_b_reg <= timer_b_next;
            end
            if (out_adv)
            begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_armed_reg <= armed_next;
            res_mode_reg  <= (mode_next == MODE_B);
            res_wr_reg    <= wr;
            res_wv_reg    <= wr && wv;
            res_gen_reg   <= gen;
        end
    end

    assign out_valid          = out_vld_reg;
    assign ctrl_armed         = res_armed_reg;
    assign mode_b             = res_mode_reg;
    assign arm_write          = res_wr_reg;
    assign arm_value          = res_wv_reg;
    assign gen_control_active = res_gen_reg;

    `GSMC_ASSERT_IMPLY(a_val_needs_write, out_vld_reg && res_wv_reg, res_wr_reg, "arm value without write")
    `GSMC_ASSERT_IMPLY(a_gen_mode_a, out_vld_reg && res_gen_reg, !res_mode_reg, "gen control in mode b")
    `GSMC_ASSERT_IMPLY(a_timer_a_idle_b, mode_reg == MODE_B, timer_a_reg == '0, "timer a runs in mode b")
    `GSMC_ASSERT_IMPLY(a_timer_b_idle_a, mode_reg == MODE_A, timer_b_reg == '0, "timer b runs in mode a")
    `GSMC_ASSERT_IMPLY(a_ready_free, !out_vld_reg, in_ready, "input stalled with empty output")

endmodule

/* tb/tb_grid_sync_mode_controller_unit.sv */
`timescale 1ns / 1ps
// self-checking testbench for grid_sync_mode_controller_unit: directed and random
// transactions checked against an in-bench predictor; depends on gsmc_pkg and the rtl
module tb_grid_sync_mode_controller_unit;
    import gsmc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [PERIOD_W-1:0] TIMER_MAX = '1;
    // a little above 2^36, reached after seventeen of the largest steps
    localparam logic [PERIOD_W-1:0] WIDE_PERIOD = 48'h0010_0000_0005;

    typedef struct {
        cmd_t                     cmd;
        logic [STEP_W-1:0]        step_ns;
        logic                     switch_closed;
        logic                     check_armed;
        logic signed [FREQ_W-1:0] freq_diff;
        logic signed [VOLT_W-1:0] volt_diff_a;
        logic signed [VOLT_W-1:0] volt_diff_b;
        logic signed [VOLT_W-1:0] volt_diff_c;
    } sync_sample_t;

    typedef struct {
        logic ctrl_armed;
        logic mode_b;
        logic arm_write;
        logic arm_value;
        logic gen_control_active;
    } sync_verdict_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [ADDR_W-1:0]         paddr = '0;
    logic [DATA_W-1:0]         pwdata = '0;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [1:0]                cmd = '0;
    logic [STEP_W-1:0]         step_ns = '0;
    logic                      switch_closed = 1'b0;
    logic                      check_armed = 1'b0;
    logic signed [FREQ_W-1:0]  freq_diff = '0;
    logic signed [VOLT_W-1:0]  volt_diff_a = '0;
    logic signed [VOLT_W-1:0]  volt_diff_b = '0;
    logic signed [VOLT_W-1:0]  volt_diff_c = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic                      ctrl_armed;
    logic                      mode_b;
    logic                      arm_write;
    logic                      arm_value;
    logic                      gen_control_active;

    // predictor copy of the limits and controller state
    cfg_t lim = '{freq_tol_upper: FREQ_UPPER_RST, freq_tol_lower: FREQ_LOWER_RST,
                  volt_tol: VOLT_TOL_RST, control_period_ns: CTRL_PER_RST,
                  monitor_period_ns: MON_PER_RST};
    bit                  ctl_armed = 1'b0;
    mode_t               ctl_mode = MODE_A;
    logic [PERIOD_W-1:0] hold_ns = '0;
    logic [PERIOD_W-1:0] watch_ns = '0;
    bit                  check_flag = 1'b0;

    sync_verdict_t verdict_q[$];
    sync_verdict_t want;
    int            fail_count = 0;
    int            cycle_count = 0;
    int            src_idle_pct = 0;
    int            sink_stall_pct = 0;

    grid_sync_mode_controller_unit i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .cmd                (cmd),
        .step_ns            (step_ns),
        .switch_closed      (switch_closed),
        .check_armed        (check_armed),
        .freq_diff          (freq_diff),
        .volt_diff_a        (volt_diff_a),
        .volt_diff_b        (volt_diff_b),
        .volt_diff_c        (volt_diff_c),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .ctrl_armed         (ctrl_armed),
        .mode_b             (mode_b),
        .arm_write          (arm_write),
        .arm_value          (arm_value),
        .gen_control_active (gen_control_active)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [PERIOD_W-1:0] sat_add(input logic [PERIOD_W-1:0] t,
                                                    input logic [STEP_W-1:0] d);
        logic [PERIOD_W:0] sum;
        sum = {1'b0, t} + {{(PERIOD_W + 1 - STEP_W){1'b0}}, d};
        return sum[PERIOD_W] ? TIMER_MAX : sum[PERIOD_W-1:0];
    endfunction

    function automatic sync_verdict_t controller_step(input sync_sample_t s);
        sync_verdict_t v;
        bit wr;
        bit wv;
        bit gen;
        bit ok;
        int fd;
        int lo;
        int hi;
        int tol;
        int va;
        int vb;
        int vc;
        wr = 1'b0;
        wv = 1'b0;
        gen = 1'b0;
        fd = int'(s.freq_diff);
        lo = int'(lim.freq_tol_lower);
        hi = int'(lim.freq_tol_upper);
        tol = int'(lim.volt_tol);
        va = int'(s.volt_diff_a);
        vb = int'(s.volt_diff_b);
        vc = int'(s.volt_diff_c);
        // signed compare against the tolerance, not a magnitude check
        ok = fd >= lo && fd <= hi && va <= tol && vb <= tol && vc <= tol;
        case (s.cmd)
            CMD_ARM: ctl_armed = 1'b1;
            CMD_DISARM: ctl_armed = 1'b0;
            CMD_TICK:
            begin
                if (ctl_armed)
                begin
                    if (s.switch_closed)
                        ctl_armed = 1'b0;
                    else if (ctl_mode == MODE_A)
                    begin
                        hold_ns = ok ? sat_add(hold_ns, s.step_ns) : '0;
                        if (hold_ns >= lim.control_period_ns)
                        begin
                            hold_ns = '0;
                            watch_ns = '0;
                            ctl_mode = MODE_B;
                            wr = 1'b1;
                            wv = 1'b1;
                        end
                        else
                        begin
                            if (s.check_armed)
                            begin
                                wr = 1'b1;
                                wv = 1'b0;
                            end
                            gen = 1'b1;
                        end
                    end
                    else if (ok)
                    begin
                        if (!s.check_armed)
                        begin
                            wr = 1'b1;
                            wv = 1'b1;
                        end
                        watch_ns = sat_add(watch_ns, s.step_ns);
                        // expiry overrides the arm write of the same tick
                        if (watch_ns >= lim.monitor_period_ns)
                        begin
                            hold_ns = '0;
                            watch_ns = '0;
                            ctl_mode = MODE_A;
                            wr = 1'b1;
                            wv = 1'b0;
                        end
                    end
                    else
                    begin
                        hold_ns = '0;
                        watch_ns = '0;
                        ctl_mode = MODE_A;
                        wr = 1'b1;
                        wv = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        if (wr)
            check_flag = wv;
        v.ctrl_armed = ctl_armed;
        v.mode_b = (ctl_mode == MODE_B);
        v.arm_write = wr;
        v.arm_value = wr && wv;
        v.gen_control_active = gen;
        return v;
    endfunction

    function automatic sync_sample_t sample_cmd(input cmd_t c);
        sync_sample_t s;
        s.cmd = c;
        s.step_ns = $urandom;
        s.switch_closed = 1'($urandom_range(1));
        s.check_armed = 1'($urandom_range(1));
        s.freq_diff = FREQ_W'(int'($urandom_range(0, 1000000)) - 500000);
        s.volt_diff_a = VOLT_W'($urandom);
        s.volt_diff_b = VOLT_W'($urandom);
        s.volt_diff_c = VOLT_W'($urandom);
        return s;
    endfunction

    function automatic sync_sample_t sample_tick(input logic [STEP_W-1:0] step, input bit closed,
                                                 input bit chk, input int fd, input int va,
                                                 input int vb, input int vc);
        sync_sample_t s;
        s.cmd = CMD_TICK;
        s.step_ns = step;
        s.switch_closed = closed;
        s.check_armed = chk;
        s.freq_diff = FREQ_W'(fd);
        s.volt_diff_a = VOLT_W'(va);
        s.volt_diff_b = VOLT_W'(vb);
        s.volt_diff_c = VOLT_W'(vc);
        return s;
    endfunction

    // metrics drawn inside the current window
    function automatic sync_sample_t passing_metrics(input sync_sample_t s);
        int lo;
        int hi;
        int tol;
        lo = int'(lim.freq_tol_lower);
        hi = int'(lim.freq_tol_upper);
        tol = int'(lim.volt_tol);
        if (lo <= hi)
            s.freq_diff = FREQ_W'(lo + int'($urandom_range(0, hi - lo)));
        s.volt_diff_a = VOLT_W'(tol - int'($urandom_range(0, tol + 32768)));
        s.volt_diff_b = VOLT_W'(tol - int'($urandom_range(0, tol + 32768)));
        s.volt_diff_c = VOLT_W'(tol - int'($urandom_range(0, tol + 32768)));
        return s;
    endfunction

    function automatic sync_sample_t random_sample();
        sync_sample_t s;
        int pick;
        s = sample_cmd(CMD_TICK);
        pick = $urandom_range(99);
        if (ctl_armed)
        begin
            if (pick < 88)
                s.cmd = CMD_TICK;
            else if (pick < 92)
                s.cmd = CMD_ARM;
            else if (pick < 96)
                s.cmd = CMD_DISARM;
            else
                s.cmd = CMD_NOP;
        end
        else
        begin
            if (pick < 60)
                s.cmd = CMD_ARM;
            else if (pick < 80)
                s.cmd = CMD_TICK;
            else if (pick < 90)
                s.cmd = CMD_DISARM;
            else
                s.cmd = CMD_NOP;
        end
        s.switch_closed = ($urandom_range(99) < 4);
        // mostly a check unit that follows the writes, sometimes a stale readback
        if ($urandom_range(99) < 85)
            s.check_armed = check_flag;
        pick = $urandom_range(99);
        if (pick < 10)
            s.step_ns = '0;
        else if (pick < 85)
            s.step_ns = $urandom_range(1, 600);
        if ($urandom_range(99) < 90)
            s = passing_metrics(s);
        return s;
    endfunction

    function automatic logic [PERIOD_W-1:0] random_period();
        int pick;
        pick = $urandom_range(99);
        if (pick < 4)
            return '0;
        else if (pick < 8)
            return TIMER_MAX;
        else if (pick < 12)
            return PERIOD_W'(1);
        return PERIOD_W'($urandom_range(1, 3000));
    endfunction

    task automatic check_field(input string name, input logic exp_v, input logic got_v);
        if (got_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, exp_v, got_v);
            fail_count++;
        end
    endtask

    // result side: random stalls and in-order compare
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: result transaction with nothing expected", $time);
                    fail_count++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    check_field("ctrl_armed", want.ctrl_armed, ctrl_armed);
                    check_field("mode_b", want.mode_b, mode_b);
                    check_field("arm_write", want.arm_write, arm_write);
                    check_field("arm_value", want.arm_value, arm_value);
                    check_field("gen_control_active", want.gen_control_active,
                                gen_control_active);
                end
            end
            out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic send_sample(input sync_sample_t s);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= s.cmd;
        step_ns <= s.step_ns;
        switch_closed <= s.switch_closed;
        check_armed <= s.check_armed;
        freq_diff <= s.freq_diff;
        volt_diff_a <= s.volt_diff_a;
        volt_diff_b <= s.volt_diff_b;
        volt_diff_c <= s.volt_diff_c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        verdict_q.push_back(controller_step(s));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, {IDX_LSB{1'b0}}};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_FREQ_UPPER: lim.freq_tol_upper = val[FREQ_W-1:0];
            REG_FREQ_LOWER: lim.freq_tol_lower = val[FREQ_W-1:0];
            REG_VOLT_TOL:   lim.volt_tol = val[VTOL_W-1:0];
            REG_CTRL_PER:   lim.control_period_ns = val[PERIOD_W-1:0];
            REG_MON_PER:    lim.monitor_period_ns = val[PERIOD_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // only written with no transaction in flight
    task automatic set_limits(input logic signed [FREQ_W-1:0] upper,
                              input logic signed [FREQ_W-1:0] lower,
                              input logic [VTOL_W-1:0] vtol,
                              input logic [PERIOD_W-1:0] ctrl_per,
                              input logic [PERIOD_W-1:0] mon_per);
        drain_results();
        reg_write(REG_FREQ_UPPER, 64'(upper));
        reg_write(REG_FREQ_LOWER, 64'(lower));
        reg_write(REG_VOLT_TOL, 64'(vtol));
        reg_write(REG_CTRL_PER, 64'(ctrl_per));
        reg_write(REG_MON_PER, 64'(mon_per));
    endtask

    task automatic random_limits();
        int                up;
        int                lo;
        logic [VTOL_W-1:0] vt;
        int                pick;
        pick = $urandom_range(9);
        case (pick)
            0:
            begin
                lo = int'($urandom_range(1, 500000));
                up = lo - int'($urandom_range(1, 1000));
            end
            1:
            begin
                lo = -500000;
                up = 500000;
            end
            2:
            begin
                lo = int'($urandom_range(0, 1000)) - 500;
                up = lo;
            end
            default:
            begin
                lo = int'($urandom_range(0, 3000)) - 2000;
                up = lo + int'($urandom_range(0, 3000));
            end
        endcase
        pick = $urandom_range(9);
        if (pick == 0)
            vt = '0;
        else if (pick == 1)
            vt = '1;
        else
            vt = VTOL_W'($urandom_range(0, 800));
        set_limits(FREQ_W'(up), FREQ_W'(lo), vt, random_period(), random_period());
    endtask

    // default limits, plain commands, the reserved command and ticks while disarmed and armed
    task automatic test_commands();
        send_sample(sample_tick(100, 1'b0, 1'b1, 300, 0, 0, 0));
        send_sample(sample_cmd(CMD_NOP));
        send_sample(sample_cmd(CMD_DISARM));
        send_sample(sample_cmd(CMD_ARM));
        send_sample(sample_cmd(CMD_NOP));
        send_sample(sample_tick(1000, 1'b0, 1'b1, 300, 0, 0, 0));
    endtask

    // mode a hold, entry to mode b, re-arm of the check and monitor expiry
    task automatic test_mode_handover();
        set_limits(660, 120, 100, 100, 250);
        send_sample(sample_tick(60, 1'b0, 1'b0, 0, 0, 0, 0));
        send_sample(sample_tick(60, 1'b0, 1'b1, 300, -50, 100, 0));
        send_sample(sample_tick(60, 1'b0, 1'b0, 660, -50, 100, 0));
        send_sample(sample_tick(100, 1'b0, 1'b0, 120, 0, 0, 0));
        send_sample(sample_tick(100, 1'b0, 1'b1, 300, 0, 0, 0));
        // check not armed and monitor expiring in the same tick
        send_sample(sample_tick(100, 1'b0, 1'b0, 300, 0, 0, 0));
        send_sample(sample_tick(100, 1'b0, 1'b1, 700, 0, 0, 0));
    endtask

    // window edges and extreme values of the step and voltage fields
    task automatic test_tolerance_edges();
        set_limits(1000, -1000, 0, 2000, 1);
        send_sample(sample_tick(1000, 1'b0, 1'b0, 1000, 0, 0, 0));
        send_sample(sample_tick(32'hFFFF_FFFF, 1'b0, 1'b0, -1000, -32768, -32768, 0));
        send_sample(sample_tick(0, 1'b0, 1'b1, 1001, 0, 0, 0));
        send_sample(sample_tick(0, 1'b0, 1'b0, 0, 1, 0, 0));
        set_limits(500000, -500000, 15'h7FFF, 10, 5);
        send_sample(sample_tick(10, 1'b0, 1'b0, 500000, 32767, 32767, 32767));
        send_sample(sample_tick(5, 1'b0, 1'b1, -500000, -32768, 0, 32767));
    endtask

    task automatic test_breaker_close();
        send_sample(sample_cmd(CMD_ARM));
        send_sample(sample_tick(50, 1'b1, 1'b1, 0, 0, 0, 0));
        send_sample(sample_tick(50, 1'b0, 1'b1, 0, 0, 0, 0));
        send_sample(sample_cmd(CMD_ARM));
    endtask

    // inverted and equal frequency bounds, zero periods
    task automatic test_odd_limits();
        set_limits(-5, 5, 100, 0, 0);
        send_sample(sample_tick(0, 1'b0, 1'b0, 0, 0, 0, 0));
        send_sample(sample_tick(0, 1'b0, 1'b1, 0, 0, 0, 0));
        set_limits(7, 7, 100, 1000, 0);
        send_sample(sample_tick(1000, 1'b0, 1'b0, 7, 0, 0, 0));
        send_sample(sample_tick(0, 1'b0, 1'b0, 7, 0, 0, 0));
    endtask

    task automatic random_phase();
        repeat (4)
        begin
            random_limits();
            repeat (150)
                send_sample(random_sample());
        end
    endtask

    // both timers run with the largest steps well past 32 bits before each period is reached
    task automatic test_wide_timers();
        sync_sample_t s;
        set_limits(0, 0, 0, TIMER_MAX, TIMER_MAX);
        send_sample(sample_cmd(CMD_ARM));
        send_sample(sample_tick(0, 1'b0, 1'b0, 1, 0, 0, 0));
        set_limits(500000, -500000, 15'h7FFF, WIDE_PERIOD, WIDE_PERIOD);
        do
        begin
            s = passing_metrics(sample_tick(32'hFFFF_FFFF, 1'b0, check_flag, 0, 0, 0, 0));
            send_sample(s);
        end
        while (ctl_mode == MODE_A);
        while (ctl_mode == MODE_B)
        begin
            s = passing_metrics(sample_tick(32'hFFFF_FFFF, 1'b0, check_flag, 0, 0, 0, 0));
            send_sample(s);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 32;
        sink_stall_pct = 72;
        test_commands();
        test_mode_handover();
        test_tolerance_edges();
        test_breaker_close();
        test_odd_limits();
        random_phase();

        src_idle_pct = 72;
        sink_stall_pct = 32;
        random_phase();

        src_idle_pct = 0;
        sink_stall_pct = 0;
        random_phase();
        test_wide_timers();

        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && verdict_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/gsmc_pkg.sv
sv/gsmc_regs.sv
sv/grid_sync_mode_controller_unit.sv
tb/tb_grid_sync_mode_controller_unit.sv
